### design/pfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID filtered derivative package
// Shared widths, register indexes, multiplier operation codes, the command
// bundle from controller to datapath and the 32-bit saturation helper.
// ----------------------------------------------------------------------------
package pfd_pkg;

    localparam int DATA_W    = 32;
    localparam int DT_W      = 20;
    localparam int OPD_W     = 33;
    localparam int PROD_W    = 2 * OPD_W;
    localparam int SUM_W     = PROD_W + 2;
    localparam int S_TDATA_W = 88;
    localparam int CFG_IDX_W = 3;
    localparam int OP_W      = 3;

    // pi scaled by 2^29, rounded to nearest
    localparam longint PI_Q29 = 64'sd1686629713;

    localparam logic [CFG_IDX_W-1:0] IDX_PROP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_INTEG  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_DERIV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_FILTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_WRAP   = 3'd4;

    localparam logic [OP_W-1:0] OP_NDT   = 3'd0;
    localparam logic [OP_W-1:0] OP_KDN   = 3'd1;
    localparam logic [OP_W-1:0] OP_EDT   = 3'd2;
    localparam logic [OP_W-1:0] OP_KPE   = 3'd3;
    localparam logic [OP_W-1:0] OP_KIS   = 3'd4;
    localparam logic [OP_W-1:0] OP_DC    = 3'd5;
    localparam logic [OP_W-1:0] OP_KDIFF = 3'd6;

    typedef struct packed {
        logic            load;
        logic            calc_err;
        logic            wrap_err;
        logic            load_diff;
        logic            mul_en;
        logic [OP_W-1:0] mul_op;
        logic            finish;
        logic            clear_integ;
    } pfd_cmd_t;

    typedef struct packed {
        logic                     flag;
        logic signed [DATA_W-1:0] val;
    } clamp_t;

    function automatic clamp_t sat32(input logic signed [SUM_W-1:0] x);
        logic [SUM_W-DATA_W:0] upper;
        clamp_t                r;
        upper = x[SUM_W-1:DATA_W-1];
        if ((&upper) || (~|upper)) begin
            r.flag = 1'b0;
            r.val  = x[DATA_W-1:0];
        end else begin
            r.flag = 1'b1;
            r.val  = x[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

### design/pfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID filtered derivative controller
// Sequences one control step through the shared multiplier and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module pfd_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              s_clear,
    output logic              m_tvalid,
    input  logic              m_tready,
    output pfd_pkg::pfd_cmd_t cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ERR  = 4'd1;
    localparam logic [3:0] ST_WRAP = 4'd2;
    localparam logic [3:0] ST_MK   = 4'd3;
    localparam logic [3:0] ST_MS   = 4'd4;
    localparam logic [3:0] ST_MP   = 4'd5;
    localparam logic [3:0] ST_MI   = 4'd6;
    localparam logic [3:0] ST_MD   = 4'd7;
    localparam logic [3:0] ST_MX   = 4'd8;
    localparam logic [3:0] ST_SUM  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       s_fire;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_clear) begin
                        cmd.clear_integ = 1'b1;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = ST_ERR;
                    end
                end
            end
            ST_ERR: begin
                cmd.calc_err = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = pfd_pkg::OP_NDT;
                state_next   = ST_WRAP;
            end
            ST_WRAP: begin
                cmd.wrap_err = 1'b1;
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = pfd_pkg::OP_KDN;
                state_next   = ST_MK;
            end
            ST_MK: begin
                cmd.load_diff = 1'b1;
                cmd.mul_en    = 1'b1;
                cmd.mul_op    = pfd_pkg::OP_EDT;
                state_next    = ST_MS;
            end
            ST_MS: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = pfd_pkg::OP_KPE;
                state_next = ST_MP;
            end
            ST_MP: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = pfd_pkg::OP_KIS;
                state_next = ST_MI;
            end
            ST_MI: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = pfd_pkg::OP_DC;
                state_next = ST_MD;
            end
            ST_MD: begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = pfd_pkg::OP_KDIFF;
                state_next = ST_MX;
            end
            ST_MX: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_clear_no_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_clear && !out_valid_reg) |=> !m_tvalid)
        else $error("clear command produced an output word");

    a_word_from_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SUM))
        else $error("output word raised outside the final state");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SUM && out_valid_reg && !m_tready) |=> (state_reg == ST_SUM))
        else $error("final result overwrote a stalled output word");
`endif

endmodule

### design/pfd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID filtered derivative datapath
// Configuration registers, loop state, one shared registered 33 by 33
// multiplier and a single saturating adder for post-processing.
// ----------------------------------------------------------------------------
module pfd_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  pfd_pkg::pfd_cmd_t                     cmd,
    input  logic [pfd_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic                                  cfg_wen,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pfd_pkg::DATA_W-1:0]            cfg_wdata,
    output logic [pfd_pkg::DATA_W-1:0]            drive,
    output logic                                  saturated
);

    localparam int DW  = pfd_pkg::DATA_W;
    localparam int OW  = pfd_pkg::OPD_W;
    localparam int PW  = pfd_pkg::PROD_W;
    localparam int SW  = pfd_pkg::SUM_W;
    localparam int TW  = pfd_pkg::DT_W;
    localparam longint PiL = (pfd_pkg::PI_Q29 + (64'sd1 <<< (28 - FRAC_BITS)))
                             >>> (29 - FRAC_BITS);
    localparam logic signed [DW+1:0] PI_Q     = (DW+2)'(PiL);
    localparam logic signed [DW+1:0] TWO_PI_Q = (DW+2)'(2 * PiL);
    localparam logic signed [SW-1:0] ONE_Q    = SW'(1) << FRAC_BITS;

    logic signed [DW-1:0] kp_reg, ki_reg, kd_reg;
    logic        [DW-1:0] rate_reg;
    logic                 wrap_reg;

    logic signed [DW-1:0] sp_reg, ms_reg;
    logic        [TW-1:0] dt_reg;
    logic signed [DW-1:0] e_reg, c_reg, k_reg, s_reg, p_reg;
    logic signed [OW-1:0] diff_reg;
    logic signed [SW-1:0] dacc_reg;
    logic signed [DW-1:0] prev_reg, deriv_reg, integ_reg;
    logic                 sat_reg;
    logic signed [DW-1:0] drive_reg;
    logic                 out_sat_reg;

    logic signed [OW-1:0]        a_op, b_op;
    logic signed [PW-1:0]        prod_reg;
    logic [pfd_pkg::OP_W-1:0]    prod_op_reg;
    logic                        prod_vld_reg;

    logic signed [PW-1:0]   shifted;
    logic signed [SW-1:0]   floor_val;
    logic signed [SW-1:0]   post_sum;
    pfd_pkg::clamp_t        post_cl;
    logic signed [SW-1:0]   err_sum;
    pfd_pkg::clamp_t        err_cl;
    logic signed [DW+1:0]   e_ext;
    logic signed [DW+1:0]   e_wrapped;
    logic signed [SW-1:0]   total_sum;
    pfd_pkg::clamp_t        total_cl;
    logic                   post_flag;

    always_comb begin
        case (cmd.mul_op)
            pfd_pkg::OP_NDT: begin
                a_op = {1'b0, rate_reg};
                b_op = {{(OW-TW){1'b0}}, dt_reg};
            end
            pfd_pkg::OP_KDN: begin
                a_op = {kd_reg[DW-1], kd_reg};
                b_op = {1'b0, rate_reg};
            end
            pfd_pkg::OP_EDT: begin
                a_op = {e_reg[DW-1], e_reg};
                b_op = {{(OW-TW){1'b0}}, dt_reg};
            end
            pfd_pkg::OP_KPE: begin
                a_op = {kp_reg[DW-1], kp_reg};
                b_op = {e_reg[DW-1], e_reg};
            end
            pfd_pkg::OP_KIS: begin
                a_op = {ki_reg[DW-1], ki_reg};
                b_op = {s_reg[DW-1], s_reg};
            end
            pfd_pkg::OP_DC: begin
                a_op = {deriv_reg[DW-1], deriv_reg};
                b_op = {c_reg[DW-1], c_reg};
            end
            pfd_pkg::OP_KDIFF: begin
                a_op = {k_reg[DW-1], k_reg};
                b_op = diff_reg;
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    always_comb begin
        shifted   = prod_reg >>> FRAC_BITS;
        floor_val = {{(SW-PW){shifted[PW-1]}}, shifted};
        case (prod_op_reg)
            pfd_pkg::OP_NDT:   post_sum = ONE_Q - floor_val;
            pfd_pkg::OP_KIS:   post_sum = {{(SW-DW){integ_reg[DW-1]}}, integ_reg} + floor_val;
            pfd_pkg::OP_KDIFF: post_sum = dacc_reg + floor_val;
            default:           post_sum = floor_val;
        endcase
        post_cl   = pfd_pkg::sat32(post_sum);
        post_flag = prod_vld_reg && post_cl.flag && (prod_op_reg != pfd_pkg::OP_DC);

        err_sum = {{(SW-DW){sp_reg[DW-1]}}, sp_reg} - {{(SW-DW){ms_reg[DW-1]}}, ms_reg};
        err_cl  = pfd_pkg::sat32(err_sum);

        e_ext = {{2{e_reg[DW-1]}}, e_reg};
        if (e_ext < -PI_Q) begin
            e_wrapped = e_ext + TWO_PI_Q;
        end else if (e_ext > PI_Q) begin
            e_wrapped = e_ext - TWO_PI_Q;
        end else begin
            e_wrapped = e_ext;
        end

        total_sum = {{(SW-DW){p_reg[DW-1]}}, p_reg}
                  + {{(SW-DW){integ_reg[DW-1]}}, integ_reg}
                  + {{(SW-DW){deriv_reg[DW-1]}}, deriv_reg};
        total_cl  = pfd_pkg::sat32(total_sum);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            rate_reg     <= '0;
            wrap_reg     <= 1'b0;
            prev_reg     <= '0;
            deriv_reg    <= '0;
            integ_reg    <= '0;
            prod_vld_reg <= 1'b0;
            sat_reg      <= 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    pfd_pkg::IDX_PROP:   kp_reg   <= cfg_wdata;
                    pfd_pkg::IDX_INTEG:  ki_reg   <= cfg_wdata;
                    pfd_pkg::IDX_DERIV:  kd_reg   <= cfg_wdata;
                    pfd_pkg::IDX_FILTER: rate_reg <= cfg_wdata;
                    pfd_pkg::IDX_WRAP:   wrap_reg <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
            prod_vld_reg <= cmd.mul_en;
            if (cmd.load) begin
                sat_reg <= 1'b0;
            end else begin
                sat_reg <= sat_reg | post_flag | (cmd.calc_err & err_cl.flag);
            end
            if (cmd.clear_integ) begin
                integ_reg <= '0;
            end else if (prod_vld_reg && prod_op_reg == pfd_pkg::OP_KIS) begin
                integ_reg <= post_cl.val;
            end
            if (prod_vld_reg && prod_op_reg == pfd_pkg::OP_KDIFF) begin
                deriv_reg <= post_cl.val;
                prev_reg  <= e_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg    <= a_op * b_op;
        prod_op_reg <= cmd.mul_op;
        if (cmd.load) begin
            sp_reg <= s_tdata[DW-1:0];
            ms_reg <= s_tdata[2*DW-1:DW];
            dt_reg <= s_tdata[2*DW+TW-1:2*DW];
        end
        if (cmd.calc_err) begin
            e_reg <= err_cl.val;
        end else if (cmd.wrap_err && wrap_reg) begin
            e_reg <= e_wrapped[DW-1:0];
        end
        if (cmd.load_diff) begin
            diff_reg <= {e_reg[DW-1], e_reg} - {prev_reg[DW-1], prev_reg};
        end
        if (prod_vld_reg) begin
            case (prod_op_reg)
                pfd_pkg::OP_NDT: c_reg    <= post_cl.val;
                pfd_pkg::OP_KDN: k_reg    <= post_cl.val;
                pfd_pkg::OP_EDT: s_reg    <= post_cl.val;
                pfd_pkg::OP_KPE: p_reg    <= post_cl.val;
                pfd_pkg::OP_DC:  dacc_reg <= floor_val;
                default: begin
                end
            endcase
        end
        if (cmd.finish) begin
            drive_reg   <= total_cl.val;
            out_sat_reg <= sat_reg | total_cl.flag;
        end
    end

    assign drive     = drive_reg;
    assign saturated = out_sat_reg;

`ifndef SYNTHESIS
    a_no_product_at_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> !prod_vld_reg)
        else $error("result formed while a product was still pending");

    a_flags_cleared_on_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !sat_reg)
        else $error("saturation flag carried over into a new step");

    a_prev_follows_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (prod_vld_reg && prod_op_reg == pfd_pkg::OP_KDIFF) |=> (prev_reg == e_reg))
        else $error("previous error not updated with the current error");
`endif

endmodule

### design/pid_filtered_derivative_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID controller with filtered derivative
// Fixed-point PID step with optional angle wrap, saturating sums and a
// forward-Euler filtered derivative term.
// ----------------------------------------------------------------------------
// Usage:
// An input word carries setpoint, measurement and time step in tdata and the
// command in tuser. Command 0 runs one control step and returns one output
// word (drive in tdata, saturation flag in tuser); command 1 clears the
// integral in the cycle it is accepted and returns nothing.
// A control step holds the block from when the word is taken until the result
// is offered, through states ERR, WRAP, MK, MS, MP, MI, MD, MX and SUM; the
// single shared 33 by 33 multiplier forms seven registered products in turn.
// s_tready is high whenever no step is in progress, even while a previous
// result still waits on the output; a stalled receiver holds only the final
// stage, which waits until the output register is free.
// Reset clears the gains, the filter rate, the wrap enable, the integral,
// the derivative term and the previous error, and drops m_tvalid.
// Configuration writes take effect at once; they must be made only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module pid_filtered_derivative_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // setpoint [31:0], measured [63:32], time_step [83:64], zero fill above
    input  logic [pfd_pkg::S_TDATA_W-1:0]       s_tdata,
    // command [0]
    input  logic [0:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // drive [31:0]
    output logic [pfd_pkg::DATA_W-1:0]          m_tdata,
    // saturated [0]
    output logic [0:0]                          m_tuser,
    input  logic                                cfg_wen,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pfd_pkg::DATA_W-1:0]          cfg_wdata
);

    pfd_pkg::pfd_cmd_t cmd;
    logic              sat_bit;

    pfd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_clear  (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    pfd_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .s_tdata   (s_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .drive     (m_tdata),
        .saturated (sat_bit)
    );

    assign m_tuser = sat_bit;

endmodule
